@@ hdl/drqd_pkg.sv @@
`default_nettype none

package drqd_pkg;

    // Default sizing of the request queues.
    localparam int QUEUE_DEPTH_DEF = 10;
    localparam int CHANNELS_DEF    = 4;

    // Field widths of the channels.
    localparam int KIND_W     = 2;
    localparam int CHAN_IN_W  = 3;
    localparam int CHAN_OUT_W = 2;
    localparam int ADDR_W     = 32;
    localparam int BYTES_W    = 16;
    localparam int COUNT_W    = 15;
    localparam int HOLDOFF_W  = 8;

    // Request store sizing for the default configuration.
    localparam int MEM_AW_DEF    = 6;
    localparam int MEM_DEPTH_DEF = 64;

    // Holdoff reload value after reset.
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 8'd1;

    // Channels that dispatch in sound FIFO repeat mode.
    localparam int SOUND_CH_A = 1;
    localparam int SOUND_CH_B = 2;

    // Shared add-and-wrap unit.
    localparam int ALU_W = 8;
    localparam logic [ALU_W:0]   ALU_NO_WRAP   = {1'b1, {ALU_W{1'b0}}};
    localparam logic [ALU_W-1:0] ALU_MINUS_ONE = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_IRQ  = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  source;
        logic [ADDR_W-1:0]  dest;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic                  is_dispatch;
        logic                  accepted;
        logic [CHAN_OUT_W-1:0] channel;
        logic [ADDR_W-1:0]     source;
        logic [ADDR_W-1:0]     dest;
        logic [COUNT_W-1:0]    word_count;
        logic                  sound_mode;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } ctrl_out_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W:0]   m;
    } alu_op_t;

    function automatic logic is_sound_channel(input int c);
        return (c == SOUND_CH_A) || (c == SOUND_CH_B);
    endfunction

endpackage

`default_nettype wire

@@ hdl/drqd_ifs.sv @@
`default_nettype none

// Command channel: push, interrupt or tick.
interface drqd_req_if import drqd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [CHAN_IN_W-1:0] channel;
    logic [ADDR_W-1:0]    source_address;
    logic [ADDR_W-1:0]    dest_address;
    logic [BYTES_W-1:0]   byte_size;

    modport source (output valid, kind, channel, source_address, dest_address, byte_size,
                    input ready);
    modport sink   (input valid, kind, channel, source_address, dest_address, byte_size,
                    output ready);
endinterface

// Result channel: push acknowledgements and dispatch records.
interface drqd_rsp_if import drqd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  is_dispatch;
    logic                  accepted;
    logic [CHAN_OUT_W-1:0] out_channel;
    logic [ADDR_W-1:0]     out_source;
    logic [ADDR_W-1:0]     out_dest;
    logic [COUNT_W-1:0]    word_count;
    logic                  sound_mode;
    logic                  last;

    modport source (output valid, is_dispatch, accepted, out_channel, out_source, out_dest,
                    word_count, sound_mode, last,
                    input ready);
    modport sink   (input valid, is_dispatch, accepted, out_channel, out_source, out_dest,
                    word_count, sound_mode, last,
                    output ready);
endinterface

// Configuration write channel for the holdoff reload register.
interface drqd_cfg_if import drqd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [HOLDOFF_W-1:0] holdoff_reload;

    modport source (output valid, holdoff_reload, input ready);
    modport sink   (input valid, holdoff_reload, output ready);
endinterface

`default_nettype wire

@@ hdl/drqd_alu.sv @@
`default_nettype none

module drqd_alu import drqd_pkg::*;
(
    input  alu_op_t          op,
    output logic [ALU_W-1:0] y
);

    logic [ALU_W:0] sum;

    // One adder followed by a single compare-and-subtract wrap against the modulus.
    assign sum = {1'b0, op.a} + {1'b0, op.b};
    assign y   = (sum >= op.m) ? ALU_W'(sum - op.m) : sum[ALU_W-1:0];

endmodule

`default_nettype wire

@@ hdl/drqd_mem.sv @@
`default_nettype none

module drqd_mem import drqd_pkg::*;
#(
    parameter int DEPTH = MEM_DEPTH_DEF,
    parameter int AW    = MEM_AW_DEF
)
(
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  entry_t        wdata,
    output entry_t        rdata
);

    entry_t store [DEPTH];

    // Single-port request store with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= store[addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/drqd_ctrl.sv @@
`default_nettype none

module drqd_ctrl import drqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CHANNELS    = CHANNELS_DEF,
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int AW = CW + HW
)
(
    input  logic          clk,
    input  logic          rst_n,
    drqd_req_if.sink      req,
    drqd_cfg_if.sink      cfg,
    input  logic          out_free,
    output ctrl_out_t     result,
    output logic          mem_we,
    output logic          mem_re,
    output logic [AW-1:0] mem_addr,
    output entry_t        mem_wdata,
    input  entry_t        mem_rdata
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0]        FILL_FULL = FW'(QUEUE_DEPTH);
    localparam logic [CHAN_IN_W-1:0] CH_LIMIT  = CHAN_IN_W'(CHANNELS);
    localparam logic [CW-1:0]        LAST_IDX  = CW'(CHANNELS - 1);
    localparam logic [ALU_W:0]       QD_MOD    = (ALU_W + 1)'(QUEUE_DEPTH);

    state_t                 state_reg;
    state_t                 state_next;
    logic [CHAN_IN_W-1:0]   chan_reg;
    entry_t                 entry_reg;
    logic [CW-1:0]          idx_reg;
    logic [CHANNELS-1:0]    mask_reg;
    logic [HOLDOFF_W-1:0]   reload_reg;
    logic [HOLDOFF_W-1:0]   holdoff_reg [CHANNELS];
    logic [HW-1:0]          head_reg [CHANNELS];
    logic [FW-1:0]          fill_reg [CHANNELS];

    logic                   req_fire;
    logic                   cfg_fire;
    logic                   irq_fire;
    logic                   tick_fire;
    logic                   in_ch_ok;
    logic [CW-1:0]          in_ch;
    logic                   push_ch_ok;
    logic [CW-1:0]          push_ch;
    logic                   push_ok;
    logic [CHANNELS-1:0]    tick_mask;
    logic                   cur_busy;
    logic                   idx_last;
    logic [CHANNELS-1:0]    idx_onehot;
    alu_op_t                alu_op;
    logic [ALU_W-1:0]       alu_y;
    logic                   push_commit;
    logic                   pop;
    logic                   dec;
    logic                   step;

    // Handshakes and channel decode.
    assign cfg.ready  = 1'b1;
    assign cfg_fire   = cfg.valid && cfg.ready;
    assign req_fire   = req.valid && req.ready;
    assign in_ch_ok   = req.channel < CH_LIMIT;
    assign in_ch      = in_ch_ok ? req.channel[CW-1:0] : '0;
    assign irq_fire   = req_fire && (req.kind == KIND_IRQ) && in_ch_ok;
    assign tick_fire  = req_fire && (req.kind == KIND_TICK);
    assign push_ch_ok = chan_reg < CH_LIMIT;
    assign push_ch    = push_ch_ok ? chan_reg[CW-1:0] : '0;
    assign push_ok    = push_ch_ok && (fill_reg[push_ch] < FILL_FULL);
    assign cur_busy   = holdoff_reg[idx_reg] != '0;
    assign idx_last   = idx_reg == LAST_IDX;
    assign idx_onehot = CHANNELS'(1) << idx_reg;

    // Channels that will dispatch on this tick, taken when the tick is accepted.
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            tick_mask[c] = (holdoff_reg[c] == '0) && (fill_reg[c] != '0);
        end
    end

    // Operand selection for the shared add-and-wrap unit.
    always_comb
    begin
        alu_op = '{a: '0, b: '0, m: ALU_NO_WRAP};
        unique case (state_reg)
            ST_PUSH:
            begin
                alu_op.a = ALU_W'(head_reg[push_ch]);
                alu_op.b = ALU_W'(fill_reg[push_ch]);
                alu_op.m = QD_MOD;
            end
            ST_SCAN:
            begin
                if (cur_busy)
                begin
                    alu_op.a = holdoff_reg[idx_reg];
                    alu_op.b = ALU_MINUS_ONE;
                    alu_op.m = ALU_NO_WRAP;
                end
                else
                begin
                    alu_op.a = ALU_W'(head_reg[idx_reg]);
                    alu_op.b = ALU_W'(1);
                    alu_op.m = QD_MOD;
                end
            end
            default:
            begin
            end
        endcase
    end

    drqd_alu u_alu
    (
        .op (alu_op),
        .y  (alu_y)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.kind == KIND_PUSH))
                begin
                    state_next = ST_PUSH;
                end
                else if (tick_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!cur_busy && mask_reg[idx_reg])
                begin
                    state_next = ST_EMIT;
                end
                else if (idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = idx_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of each state.
    always_comb
    begin
        req.ready   = state_reg == ST_IDLE;
        result      = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = '0;
        mem_wdata   = entry_reg;
        push_commit = 1'b0;
        pop         = 1'b0;
        dec         = 1'b0;
        step        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_PUSH:
            begin
                // The slot is written in the same cycle as the acknowledgement enters the result register.
                result.valid        = 1'b1;
                result.res.accepted = push_ok;
                result.res.channel  = push_ok ? chan_reg[CHAN_OUT_W-1:0] : '0;
                result.res.last     = 1'b1;
                push_commit         = push_ok && out_free;
                mem_we              = push_commit;
                mem_addr            = {push_ch, alu_y[HW-1:0]};
            end
            ST_SCAN:
            begin
                dec      = cur_busy;
                pop      = !cur_busy && mask_reg[idx_reg];
                mem_re   = pop;
                mem_addr = {idx_reg, head_reg[idx_reg]};
                step     = !pop;
            end
            ST_EMIT:
            begin
                result.valid           = 1'b1;
                result.res.is_dispatch = 1'b1;
                result.res.channel     = CHAN_OUT_W'(idx_reg);
                result.res.source      = mem_rdata.source;
                result.res.dest        = mem_rdata.dest;
                result.res.sound_mode  = is_sound_channel(int'(idx_reg));
                result.res.word_count  = is_sound_channel(int'(idx_reg)) ? '0 : mem_rdata.count;
                result.res.last        = (mask_reg & ~idx_onehot) == '0;
                step                   = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Control and per-channel queue state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            mask_reg   <= '0;
            reload_reg <= HOLDOFF_RESET;
            for (int c = 0; c < CHANNELS; c++)
            begin
                holdoff_reg[c] <= HOLDOFF_RESET;
                head_reg[c]    <= '0;
                fill_reg[c]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                reload_reg <= cfg.holdoff_reload;
            end

            // Channel step pointer of the tick walk.
            if (tick_fire)
            begin
                idx_reg  <= '0;
                mask_reg <= tick_mask;
            end
            else
            begin
                if (step && !idx_last)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if ((state_reg == ST_EMIT) && out_free)
                begin
                    mask_reg <= mask_reg & ~idx_onehot;
                end
            end

            if (irq_fire)
            begin
                holdoff_reg[in_ch] <= reload_reg;
            end
            if (dec)
            begin
                holdoff_reg[idx_reg] <= alu_y;
            end

            if (pop)
            begin
                head_reg[idx_reg] <= alu_y[HW-1:0];
                fill_reg[idx_reg] <= fill_reg[idx_reg] - FW'(1);
            end
            if (push_commit)
            begin
                fill_reg[push_ch] <= fill_reg[push_ch] + FW'(1);
            end
        end
    end

    // Captured command payload; the byte size is kept as a halfword count.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            chan_reg  <= req.channel;
            entry_reg <= '{source: req.source_address,
                           dest:   req.dest_address,
                           count:  req.byte_size[BYTES_W-1:1]};
        end
    end

endmodule

`default_nettype wire

@@ hdl/dma_request_queue_dispatcher.sv @@
`default_nettype none

// DMA request queue dispatcher.
// Commands enter on req: a push stores a transfer request in a channel's queue,
// an interrupt reloads a channel's holdoff counter, and a tick walks the channels
// in order, counting down holdoff or popping one request per ready channel.
// Results leave on rsp: one acknowledgement per push, and one dispatch record per
// popping channel on a tick, the final one of a tick marked with last. An
// interrupt or an unused command kind gives no result.
// The cfg channel writes the holdoff reload value; it is always ready.
// One command is handled at a time and req.ready is low while it is in progress.
// A push moves to the push state, which forms its acknowledgement and registers
// it on rsp once the result register is free. A tick walks the channels in the
// scan state, with an emit state after each pop: the request store has one port
// and the emit state uses its registered read. An interrupt needs no extra state.
// A single result register sits on rsp: when the receiver stalls, the sequencer
// holds at the next result until that register drains.
// Reset clears all queues and loads every holdoff counter and the reload register
// with 1. No clearing pass is needed; the block is ready straight after reset.
module dma_request_queue_dispatcher import drqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CHANNELS    = CHANNELS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    drqd_req_if.sink   req,
    drqd_rsp_if.source rsp,
    drqd_cfg_if.sink   cfg
);

    localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int AW        = CW + HW;
    localparam int MEM_DEPTH = CHANNELS * (2 ** HW);

    ctrl_out_t     ctrl_out;
    logic          out_free;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    entry_t        mem_wdata;
    entry_t        mem_rdata;
    logic          out_valid_reg;
    result_t       out_res_reg;

    drqd_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CHANNELS    (CHANNELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .out_free  (out_free),
        .result    (ctrl_out),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    drqd_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Result register: takes a new item whenever it is empty or being drained.
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= ctrl_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && ctrl_out.valid)
        begin
            out_res_reg <= ctrl_out.res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.is_dispatch = out_res_reg.is_dispatch;
    assign rsp.accepted    = out_res_reg.accepted;
    assign rsp.out_channel = out_res_reg.channel;
    assign rsp.out_source  = out_res_reg.source;
    assign rsp.out_dest    = out_res_reg.dest;
    assign rsp.word_count  = out_res_reg.word_count;
    assign rsp.sound_mode  = out_res_reg.sound_mode;
    assign rsp.last        = out_res_reg.last;

endmodule

`default_nettype wire

@@ hdl/drqd_checker.sv @@
`default_nettype none

module drqd_checker import drqd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic [KIND_W-1:0]     req_kind,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic                  rsp_is_dispatch,
    input logic                  rsp_accepted,
    input logic [CHAN_OUT_W-1:0] rsp_out_channel,
    input logic [ADDR_W-1:0]     rsp_out_source,
    input logic [ADDR_W-1:0]     rsp_out_dest,
    input logic [COUNT_W-1:0]    rsp_word_count,
    input logic                  rsp_sound_mode,
    input logic                  rsp_last
);

    // A stalled result stays valid and keeps its source, destination and last flag.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_source)
            && $stable(rsp_out_dest) && $stable(rsp_last))
        else $error("stalled result changed");

    // A push or a tick occupies the block for at least the following cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_kind == KIND_PUSH || req_kind == KIND_TICK)
            |=> !req_ready)
        else $error("command accepted while the previous one is in progress");

    // An acknowledgement is always the only result of its push.
    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_is_dispatch |-> rsp_last && !rsp_sound_mode
            && (rsp_accepted || rsp_out_channel == '0))
        else $error("malformed push acknowledgement");

    // Dispatches never carry accepted, and sound channels, and only they, dispatch in sound mode.
    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_dispatch |-> !rsp_accepted
            && (rsp_sound_mode == (rsp_out_channel == CHAN_OUT_W'(SOUND_CH_A)
                || rsp_out_channel == CHAN_OUT_W'(SOUND_CH_B))))
        else $error("dispatch mode does not match its channel");

    // Sound mode dispatches carry no halfword count.
    a_snd_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_sound_mode |-> rsp_word_count == '0)
        else $error("sound mode dispatch with a nonzero count");

endmodule

bind dma_request_queue_dispatcher drqd_checker u_drqd_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_kind        (req.kind),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_is_dispatch (rsp.is_dispatch),
    .rsp_accepted    (rsp.accepted),
    .rsp_out_channel (rsp.out_channel),
    .rsp_out_source  (rsp.out_source),
    .rsp_out_dest    (rsp.out_dest),
    .rsp_word_count  (rsp.word_count),
    .rsp_sound_mode  (rsp.sound_mode),
    .rsp_last        (rsp.last)
);

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

module testbench;
    import drqd_pkg::*;

    localparam int NCH            = CHANNELS_DEF;
    localparam int QD             = QUEUE_DEPTH_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_STALL     = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // Command code that the block has no use for.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    drqd_req_if req_bus ();
    drqd_rsp_if rsp_bus ();
    drqd_cfg_if cfg_bus ();

    dma_request_queue_dispatcher u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // Predicted state of the queues and holdoff counters.
    logic [HOLDOFF_W-1:0] reload_value;
    logic [HOLDOFF_W-1:0] holdoff_left [NCH];
    entry_t               queue_mem    [NCH][QD];
    int unsigned          q_head       [NCH];
    int unsigned          q_fill       [NCH];

    // Results still to come out of the block, oldest first.
    result_t awaited_results [$];

    int errors         = 0;
    int stall_requests = 0;
    bit idle_on        = 1'b1;
    int quiet_cycles   = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Work out the results of one accepted item and advance the predicted state.
    function automatic void compute_results(input logic [KIND_W-1:0]    kind,
                                            input logic [CHAN_IN_W-1:0] ch,
                                            input logic [ADDR_W-1:0]    src,
                                            input logic [ADDR_W-1:0]    dst,
                                            input logic [BYTES_W-1:0]   bytes);
        result_t r;
        result_t held;
        entry_t  e;
        bit      have_held;
        bit      sound;
        int      slot;
        have_held = 1'b0;
        held      = '0;
        case (kind)
            KIND_PUSH:
            begin
                r      = '0;
                r.last = 1'b1;
                if (ch < NCH && q_fill[ch] < QD)
                begin
                    slot                       = (q_head[ch] + q_fill[ch]) % QD;
                    queue_mem[ch][slot].source = src;
                    queue_mem[ch][slot].dest   = dst;
                    queue_mem[ch][slot].count  = bytes[BYTES_W-1:1];
                    q_fill[ch]++;
                    r.accepted = 1'b1;
                    r.channel  = ch[CHAN_OUT_W-1:0];
                end
                awaited_results.push_back(r);
            end
            KIND_IRQ:
            begin
                if (ch < NCH)
                    holdoff_left[ch] = reload_value;
            end
            KIND_TICK:
            begin
                // Each dispatch is held back one step so that the final one gets last.
                for (int c = 0; c < NCH; c++)
                begin
                    if (holdoff_left[c] != 0)
                        holdoff_left[c]--;
                    else if (q_fill[c] != 0)
                    begin
                        if (have_held)
                            awaited_results.push_back(held);
                        e             = queue_mem[c][q_head[c]];
                        sound         = (c == SOUND_CH_A) || (c == SOUND_CH_B);
                        r             = '0;
                        r.is_dispatch = 1'b1;
                        r.channel     = CHAN_OUT_W'(c);
                        r.source      = e.source;
                        r.dest        = e.dest;
                        r.word_count  = sound ? '0 : e.count;
                        r.sound_mode  = sound;
                        q_head[c]     = (q_head[c] + 1) % QD;
                        q_fill[c]--;
                        held          = r;
                        have_held     = 1'b1;
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    awaited_results.push_back(held);
                end
            end
            default:
            begin
                // An unused kind leaves everything as it was.
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each result that leaves the block with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rsp_bus.valid && rsp_bus.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result expected none, got channel %0d dispatch %0b",
                         $time, rsp_bus.out_channel, rsp_bus.is_dispatch);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("is_dispatch", want.is_dispatch, rsp_bus.is_dispatch);
                check_field("accepted", want.accepted, rsp_bus.accepted);
                check_field("out_channel", want.channel, rsp_bus.out_channel);
                check_field("out_source", want.source, rsp_bus.out_source);
                check_field("out_dest", want.dest, rsp_bus.out_dest);
                check_field("word_count", want.word_count, rsp_bus.word_count);
                check_field("sound_mode", want.sound_mode, rsp_bus.sound_mode);
                check_field("last", want.last, rsp_bus.last);
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off when one is asked for.
    initial
    begin : result_sink
        int served;
        served = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_requests != served)
            begin
                served++;
                rsp_bus.ready <= 1'b0;
                repeat (LONG_STALL - 1) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge clk);
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when nothing has been accepted for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, with an optional idle burst first, and predict on acceptance.
    task automatic send_cmd(input logic [KIND_W-1:0]    kind,
                            input logic [CHAN_IN_W-1:0] ch,
                            input logic [ADDR_W-1:0]    src,
                            input logic [ADDR_W-1:0]    dst,
                            input logic [BYTES_W-1:0]   bytes);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 6);
        if (gap != 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.kind           <= kind;
        req_bus.channel        <= ch;
        req_bus.source_address <= src;
        req_bus.dest_address   <= dst;
        req_bus.byte_size      <= bytes;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        compute_results(kind, ch, src, dst, bytes);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reload(input logic [HOLDOFF_W-1:0] value);
        wait_idle();
        cfg_bus.valid          <= 1'b1;
        cfg_bus.holdoff_reload <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        reload_value = value;
        cfg_bus.valid <= 1'b0;
    endtask

    // A stream of random items with the given shares of pushes and interrupts.
    task automatic random_traffic(input int count, input int push_pct, input int irq_pct);
        logic [KIND_W-1:0]    kind;
        logic [CHAN_IN_W-1:0] ch;
        logic [BYTES_W-1:0]   bytes;
        int                   roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                kind = KIND_PUSH;
            else if (roll < push_pct + irq_pct)
                kind = KIND_IRQ;
            else if (roll < 98)
                kind = KIND_TICK;
            else
                kind = KIND_UNUSED;
            if ($urandom_range(0, 9) == 0)
                ch = CHAN_IN_W'($urandom_range(4, 7));
            else
                ch = CHAN_IN_W'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       bytes = '0;
                1:       bytes = '1;
                default: bytes = BYTES_W'($urandom);
            endcase
            send_cmd(kind, ch, $urandom, $urandom, bytes);
        end
    endtask

    // Field extremes, every command kind, bad channels, holdoff and a full queue.
    task automatic test_directed();
        send_cmd(KIND_PUSH, 3'd0, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(KIND_PUSH, 3'd1, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0001);
        send_cmd(KIND_PUSH, 3'd2, $urandom, $urandom, 16'h0000);
        send_cmd(KIND_PUSH, 3'd3, 32'hAAAA_5555, 32'h5555_AAAA, 16'hFFFE);
        send_cmd(KIND_PUSH, 3'd4, $urandom, $urandom, 16'h1234);
        send_cmd(KIND_PUSH, 3'd7, $urandom, $urandom, 16'hFFFF);
        send_cmd(KIND_UNUSED, 3'd0, $urandom, $urandom, 16'h0000);
        send_cmd(KIND_IRQ, 3'd6, 32'h0, 32'h0, 16'h0);
        // The first tick only runs the counters down from their reset value.
        send_cmd(KIND_TICK, 3'd0, 32'h0, 32'h0, 16'h0);
        send_cmd(KIND_IRQ, 3'd1, 32'h0, 32'h0, 16'h0);
        send_cmd(KIND_TICK, 3'd0, 32'h0, 32'h0, 16'h0);
        send_cmd(KIND_TICK, 3'd0, 32'h0, 32'h0, 16'h0);
        send_cmd(KIND_TICK, 3'd0, 32'h0, 32'h0, 16'h0);
        // Ten pushes fill the queue and the eleventh is turned away.
        for (int i = 0; i <= QD; i++)
            send_cmd(KIND_PUSH, 3'd2, $urandom, $urandom, 16'($urandom));
    endtask

    // Random traffic under several holdoff reload values, extremes included.
    task automatic test_reload_settings();
        write_reload(8'd0);
        random_traffic(70, 60, 10);
        write_reload(8'd255);
        random_traffic(70, 45, 3);
        write_reload(8'd3);
        random_traffic(70, 35, 15);
        write_reload(HOLDOFF_W'($urandom_range(0, 255)));
        random_traffic(35, 50, 10);
        // The sender waits here for every result before carrying on.
        wait_idle();
        random_traffic(35, 50, 10);
        write_reload(8'd1);
        random_traffic(70, 40, 10);
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        stall_requests <= stall_requests + 1;
        random_traffic(40, 50, 5);
    endtask

    // The closing part runs with no idling on either side.
    task automatic test_full_rate();
        wait_idle();
        idle_on = 1'b0;
        random_traffic(60, 40, 10);
    endtask

    initial
    begin
        for (int c = 0; c < NCH; c++)
        begin
            holdoff_left[c] = HOLDOFF_RESET;
            q_head[c]       = 0;
            q_fill[c]       = 0;
        end
        reload_value = HOLDOFF_RESET;

        rst_n                  <= 1'b0;
        req_bus.valid          <= 1'b0;
        req_bus.kind           <= KIND_PUSH;
        req_bus.channel        <= '0;
        req_bus.source_address <= '0;
        req_bus.dest_address   <= '0;
        req_bus.byte_size      <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.holdoff_reload <= HOLDOFF_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_reload_settings();
        test_backpressure();
        test_full_rate();
        wait_idle();

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ dma_request_queue_dispatcher.f @@
hdl/drqd_pkg.sv
hdl/drqd_ifs.sv
hdl/drqd_alu.sv
hdl/drqd_mem.sv
hdl/drqd_ctrl.sv
hdl/dma_request_queue_dispatcher.sv
hdl/drqd_checker.sv
verif/testbench.sv
